// ===== rtl/axis_auto_range_scaler_assert.svh =====
// ----------------------------------------------------------------------------
// axis_auto_range_scaler_assert.svh
// assertion macros shared by the auto range scaler rtl
// ----------------------------------------------------------------------------
`ifndef AXIS_AUTO_RANGE_SCALER_ASSERT_SVH
`define AXIS_AUTO_RANGE_SCALER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define ARS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ARS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ARS_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ARS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/axars_pkg.sv =====
// ----------------------------------------------------------------------------
// axars_pkg
// types and constants of the auto range scaler
// ----------------------------------------------------------------------------
package axars_pkg;

   localparam int SAMPLE_W = 24;
   localparam int POS_W    = 8;
   localparam int DEVP_W   = 3;

   localparam logic [SAMPLE_W-1:0] DEAD_LOW    = 24'h100000;
   localparam logic [SAMPLE_W-1:0] DEAD_HIGH   = 24'hF00000;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = 24'hFFFFFF;

   localparam logic [POS_W-1:0] POS_MIN     = 8'd0;
   localparam logic [POS_W-1:0] POS_MAX     = 8'd255;
   localparam logic [POS_W-1:0] POS_INVALID = 8'd128;

   // axes whose reading runs the other way
   localparam logic [2:0] AXIS_INV_A = 3'd1;
   localparam logic [2:0] AXIS_INV_B = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_MUL,
      ST_DIV,
      ST_FINISH
   } state_type;

endpackage

// ===== rtl/axis_auto_range_scaler.sv =====
// An invalid item goes from accept to FINISH; a valid item passes EVAL, then FINISH
// if a bound moves, else MUL, DIV steps and FINISH, which waits for a free result
// register. One item at a time; restoring division gives one quotient bit per cycle.
// Reset: synchronous; bounds read as the dead-space limits through per-entry valid
// bits (no clearing pass), devices_present returns to 0.
// ----------------------------------------------------------------------------
// axis_auto_range_scaler
// self-calibrating min/max range normalization of analog axis samples to 0..255
// ----------------------------------------------------------------------------
`include "axis_auto_range_scaler_assert.svh"

module axis_auto_range_scaler #(
   parameter int DEVICES = 4,
   parameter int AXES    = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [axars_pkg::DEVP_W-1:0]      csr_devices_present,
   // input items
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_device,
   input  logic [2:0]                        req_axis,
   input  logic                              req_axis_mapped,
   input  logic [31:0]                       req_raw_sample,
   // result items
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [axars_pkg::POS_W-1:0]       rsp_position,
   output logic                              rsp_bound_moved
);
   import axars_pkg::*;

   localparam int DEPTH  = DEVICES * AXES;
   localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(POS_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(POS_W - 1);

   state_type state_ff, state_in;

   logic [DEVP_W-1:0]   devp_ff, devp_in;
   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [SAMPLE_W-1:0] diff_ff, diff_in;
   logic [SAMPLE_W-1:0] span_ff, span_in;
   logic [SAMPLE_W-1:0] rem_ff, rem_in;
   logic [POS_W-1:0]    nlow_ff, nlow_in;
   logic [POS_W-1:0]    res_pos_ff, res_pos_in;
   logic                res_moved_ff, res_moved_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]    rsp_pos_ff, rsp_pos_in;
   logic                rsp_moved_ff, rsp_moved_in;

   // bound storage with per-entry written flags
   logic [SAMPLE_W-1:0] low_mem  [DEPTH];
   logic [SAMPLE_W-1:0] high_mem [DEPTH];
   logic [DEPTH-1:0]    lo_ok_vec_ff;
   logic [DEPTH-1:0]    hi_ok_vec_ff;
   logic [SAMPLE_W-1:0] lo_rd_ff, hi_rd_ff;
   logic                lo_ok_ff, hi_ok_ff;

   logic                accept;
   logic                item_ok;
   logic [SLOT_W-1:0]   req_slot;
   logic                invert;
   logic [SAMPLE_W-1:0] lo_cur, hi_cur;
   logic                below, above;
   logic [SAMPLE_W-1:0] span_raw;
   logic [31:0]         prod;
   logic [SAMPLE_W:0]   trial, trial_sub;
   logic                trial_ge;
   logic                lo_we, hi_we;
   logic [SAMPLE_W-1:0] mem_wdata;
   logic                out_free;

   assign csr_ready       = 1'b1;
   assign req_ready       = (state_ff == ST_IDLE);
   assign accept          = req_valid && req_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_position    = rsp_pos_ff;
   assign rsp_bound_moved = rsp_moved_ff;

   // input decode
   assign item_ok = ({1'b0, req_device} < devp_ff)
                 && (32'(req_device) < DEVICES)
                 && (32'(req_axis) < AXES)
                 && req_axis_mapped;
   assign req_slot = SLOT_W'(32'(req_device) * AXES + 32'(req_axis));
   assign invert   = (req_axis == AXIS_INV_A) || (req_axis == AXIS_INV_B);

   // bounds of the current slot
   assign lo_cur   = lo_ok_ff ? lo_rd_ff : DEAD_LOW;
   assign hi_cur   = hi_ok_ff ? hi_rd_ff : DEAD_HIGH;
   assign below    = sample_ff < lo_cur;
   assign above    = sample_ff > hi_cur;
   assign span_raw = hi_cur - lo_cur;

   // times 255 as a shift and subtract
   assign prod = {diff_ff, 8'd0} - {8'd0, diff_ff};

   // one restoring division step
   assign trial     = {rem_ff, nlow_ff[POS_W-1]};
   assign trial_ge  = trial >= {1'b0, span_ff};
   assign trial_sub = trial - {1'b0, span_ff};

   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state and datapath
   always_comb begin
      state_in     = state_ff;
      devp_in      = devp_ff;
      sample_in    = sample_ff;
      slot_in      = slot_ff;
      diff_in      = diff_ff;
      span_in      = span_ff;
      rem_in       = rem_ff;
      nlow_in      = nlow_ff;
      res_pos_in   = res_pos_ff;
      res_moved_in = res_moved_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_moved_in = rsp_moved_ff;
      lo_we        = 1'b0;
      hi_we        = 1'b0;
      mem_wdata    = sample_ff;

      if (csr_valid && csr_ready) begin
         devp_in = csr_devices_present;
      end

      // output register drains
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sample_in    = req_raw_sample[31:8] ^ (invert ? SAMPLE_MASK : '0);
               slot_in      = req_slot;
               res_pos_in   = POS_INVALID;
               res_moved_in = 1'b0;
               state_in     = item_ok ? ST_EVAL : ST_FINISH;
            end
         end
         ST_EVAL: begin
            diff_in = sample_ff - lo_cur;
            span_in = (span_raw == '0) ? SAMPLE_W'(1) : span_raw;
            if (below) begin
               lo_we        = 1'b1;
               mem_wdata    = (sample_ff <= DEAD_LOW) ? DEAD_LOW : sample_ff;
               res_pos_in   = POS_MIN;
               res_moved_in = 1'b1;
               state_in     = ST_FINISH;
            end else if (above) begin
               hi_we        = 1'b1;
               mem_wdata    = (sample_ff >= DEAD_HIGH) ? DEAD_HIGH : sample_ff;
               res_pos_in   = POS_MAX;
               res_moved_in = 1'b1;
               state_in     = ST_FINISH;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            rem_in     = prod[31:8];
            nlow_in    = prod[7:0];
            res_pos_in = '0;
            cnt_in     = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            rem_in     = trial_ge ? trial_sub[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
            nlow_in    = {nlow_ff[POS_W-2:0], 1'b0};
            res_pos_in = {res_pos_ff[POS_W-2:0], trial_ge};
            cnt_in     = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = res_pos_ff;
               rsp_moved_in = res_moved_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         devp_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         devp_ff      <= devp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      slot_ff      <= slot_in;
      diff_ff      <= diff_in;
      span_ff      <= span_in;
      rem_ff       <= rem_in;
      nlow_ff      <= nlow_in;
      res_pos_ff   <= res_pos_in;
      res_moved_ff <= res_moved_in;
      cnt_ff       <= cnt_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_moved_ff <= rsp_moved_in;
   end

   // bound memories, read on accept and written from evaluation
   always_ff @(posedge clock) begin
      if (lo_we) begin
         low_mem[slot_ff] <= mem_wdata;
      end
      if (hi_we) begin
         high_mem[slot_ff] <= mem_wdata;
      end
      if (accept && item_ok) begin
         lo_rd_ff <= low_mem[req_slot];
         hi_rd_ff <= high_mem[req_slot];
         lo_ok_ff <= lo_ok_vec_ff[req_slot];
         hi_ok_ff <= hi_ok_vec_ff[req_slot];
      end
   end

   // written flags
   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ok_vec_ff <= '0;
         hi_ok_vec_ff <= '0;
      end else begin
         if (lo_we) begin
            lo_ok_vec_ff[slot_ff] <= 1'b1;
         end
         if (hi_we) begin
            hi_ok_vec_ff[slot_ff] <= 1'b1;
         end
      end
   end

   // checks
   `ARS_ASSERT_IMPLIES(a_rem_below_span, clock, reset, state_ff == ST_DIV, rem_ff < span_ff)
   `ARS_ASSERT_IMPLIES(a_div_length, clock, reset, state_ff == ST_MUL, ##9 state_ff == ST_FINISH)
   `ARS_ASSERT_IMPLIES(a_moved_extreme, clock, reset, rsp_valid_ff && rsp_moved_ff, rsp_pos_ff == POS_MIN || rsp_pos_ff == POS_MAX)
   `ARS_ASSERT_NEXT(a_accept_busy, clock, reset, accept, state_ff != ST_IDLE)

endmodule
